// ===== rtl/qru_pkg.sv =====
`default_nettype none
package qru_pkg;

	typedef enum logic [3:0] {
		MODE_MAKE_X   = 4'd0,
		MODE_MAKE_Y   = 4'd1,
		MODE_MAKE_Z   = 4'd2,
		MODE_MAKE_AX  = 4'd3,
		MODE_PRE_X    = 4'd4,
		MODE_PRE_Y    = 4'd5,
		MODE_PRE_Z    = 4'd6,
		MODE_POST_X   = 4'd7,
		MODE_POST_Y   = 4'd8,
		MODE_POST_Z   = 4'd9,
		MODE_RMUL     = 4'd10,
		MODE_LMUL     = 4'd11,
		MODE_LOAD     = 4'd12,
		MODE_CONJ     = 4'd13,
		MODE_XFORM    = 4'd14,
		MODE_NONE     = 4'd15
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_AXIS,
		ST_HAM1,
		ST_HAM2,
		ST_DONE
	} state_t;

	localparam int CordicFrac = 30;
	localparam logic signed [63:0] CordicGain = 64'sd652032874;

	// Arctangent of 2^-i in units where 2^31 means pi.
	function automatic logic signed [63:0] atan_lookup(input logic [4:0] i);
		logic signed [63:0] r;
		unique case (i)
			5'd0: r = 64'sd536870912;  5'd1: r = 64'sd316933406;
			5'd2: r = 64'sd167458907;  5'd3: r = 64'sd85004756;
			5'd4: r = 64'sd42667331;   5'd5: r = 64'sd21354465;
			5'd6: r = 64'sd10680862;   5'd7: r = 64'sd5340245;
			5'd8: r = 64'sd2670163;    5'd9: r = 64'sd1335087;
			5'd10: r = 64'sd667544;    5'd11: r = 64'sd333772;
			5'd12: r = 64'sd166886;    5'd13: r = 64'sd83443;
			5'd14: r = 64'sd41722;     5'd15: r = 64'sd20861;
			5'd16: r = 64'sd10430;     5'd17: r = 64'sd5215;
			5'd18: r = 64'sd2608;      5'd19: r = 64'sd1304;
			5'd20: r = 64'sd652;       5'd21: r = 64'sd326;
			5'd22: r = 64'sd163;       5'd23: r = 64'sd81;
			5'd24: r = 64'sd41;        5'd25: r = 64'sd20;
			5'd26: r = 64'sd10;        5'd27: r = 64'sd5;
			5'd28: r = 64'sd3;         5'd29: r = 64'sd1;
			5'd30: r = 64'sd1;         default: r = 64'sd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/qru_if.sv =====
`default_nettype none
interface qru_in_if #(
	parameter int COMPONENT_WIDTH = 16,
	parameter int ANGLE_WIDTH = 16
);
	logic valid;
	logic ready;
	logic [3:0] mode;
	logic signed [ANGLE_WIDTH-1:0] angle;
	logic signed [COMPONENT_WIDTH-1:0] operand_x;
	logic signed [COMPONENT_WIDTH-1:0] operand_y;
	logic signed [COMPONENT_WIDTH-1:0] operand_z;
	logic signed [COMPONENT_WIDTH-1:0] operand_w;
	modport source (output valid, mode, angle, operand_x, operand_y, operand_z, operand_w,
		input ready);
	modport sink (input valid, mode, angle, operand_x, operand_y, operand_z, operand_w,
		output ready);
endinterface

interface qru_out_if #(
	parameter int COMPONENT_WIDTH = 16
);
	logic valid;
	logic ready;
	logic signed [COMPONENT_WIDTH-1:0] result_x;
	logic signed [COMPONENT_WIDTH-1:0] result_y;
	logic signed [COMPONENT_WIDTH-1:0] result_z;
	logic signed [COMPONENT_WIDTH-1:0] result_w;
	modport source (output valid, result_x, result_y, result_z, result_w, input ready);
	modport sink (input valid, result_x, result_y, result_z, result_w, output ready);
endinterface
`default_nettype wire

// ===== rtl/qru_cordic.sv =====
`default_nettype none
module qru_cordic #(
	parameter int COMPONENT_WIDTH = 16,
	parameter int ANGLE_WIDTH = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic signed [ANGLE_WIDTH-1:0] angle,
	output logic done,
	output logic signed [COMPONENT_WIDTH-1:0] sin_out,
	output logic signed [COMPONENT_WIDTH-1:0] cos_out
);
	localparam int FracBits = COMPONENT_WIDTH - 2;
	localparam int Sh = qru_pkg::CordicFrac - FracBits;
	localparam int IterW = $clog2(CORDIC_STEPS + 1);

	logic signed [63:0] x_q, y_q, z_q;
	logic [IterW-1:0] iter_q;
	logic busy_q;

	function automatic logic signed [COMPONENT_WIDTH-1:0] out_round(
		input logic signed [63:0] v);
		logic signed [63:0] r, hi, lo;
		hi = (64'sd1 <<< (COMPONENT_WIDTH - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (Sh == 0) r = v;
		else r = (v + (64'sd1 <<< (Sh > 0 ? Sh - 1 : 0))) >>> Sh;
		if (r > hi) r = hi;
		else if (r < lo) r = lo;
		return r[COMPONENT_WIDTH-1:0];
	endfunction

	logic signed [63:0] z_init;
	always_comb begin
		if (ANGLE_WIDTH <= 31)
			z_init = 64'(angle) <<< (31 - ANGLE_WIDTH);
		else
			z_init = 64'(angle) >>> 1;
	end

	logic [4:0] it5;
	assign it5 = 5'(iter_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			iter_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				if (iter_q == IterW'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				iter_q <= iter_q + IterW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= qru_pkg::CordicGain;
			y_q <= '0;
			z_q <= z_init;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - (y_q >>> it5);
				y_q <= y_q + (x_q >>> it5);
				z_q <= z_q - qru_pkg::atan_lookup(it5);
			end else begin
				x_q <= x_q + (y_q >>> it5);
				y_q <= y_q - (x_q >>> it5);
				z_q <= z_q + qru_pkg::atan_lookup(it5);
			end
		end
	end

	assign cos_out = out_round(x_q);
	assign sin_out = out_round(y_q);
endmodule
`default_nettype wire

// ===== rtl/qru_lane.sv =====
`default_nettype none
// One product lane: sum of four signed products, rounded half up at the
// fraction point and saturated. Sign of each product is chosen per term.
module qru_lane #(
	parameter int COMPONENT_WIDTH = 16
) (
	input  wire logic clk,
	input  wire logic signed [COMPONENT_WIDTH-1:0] a [4],
	input  wire logic signed [COMPONENT_WIDTH-1:0] b [4],
	input  wire logic [3:0] neg,
	output logic signed [COMPONENT_WIDTH-1:0] sum
);
	localparam int Fr = COMPONENT_WIDTH - 2;
	localparam int Pw = 2 * COMPONENT_WIDTH + 1;
	localparam int Sw = Pw + 3;

	logic signed [Pw-1:0] p_s1 [4];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			if (neg[i]) p_s1[i] <= -(Pw'(a[i]) * Pw'(b[i]));
			else p_s1[i] <= Pw'(a[i]) * Pw'(b[i]);
		end
	end

	logic signed [Sw-1:0] tot, rnd;
	logic signed [Sw-1:0] hi, lo;
	always_comb begin
		tot = Sw'(p_s1[0]) + Sw'(p_s1[1]) + Sw'(p_s1[2]) + Sw'(p_s1[3])
			+ (Sw'(1) <<< (Fr - 1));
		rnd = tot >>> Fr;
		hi = (Sw'(1) <<< (COMPONENT_WIDTH - 1)) - Sw'(1);
		lo = -hi - Sw'(1);
	end

	always_ff @(posedge clk) begin
		if (rnd > hi) sum <= hi[COMPONENT_WIDTH-1:0];
		else if (rnd < lo) sum <= lo[COMPONENT_WIDTH-1:0];
		else sum <= rnd[COMPONENT_WIDTH-1:0];
	end
endmodule
`default_nettype wire

// ===== rtl/quaternion_rotation_unit_core.sv =====
`default_nettype none
// Quaternion rotation unit.
// The block holds one orientation quaternion (x, y, z, w in Q1.14) that
// reset sets to identity. Words arrive on in_ch (mode, angle, operand) and
// one result word per input word leaves on out_ch: the new orientation, or
// the rotated vector in transform mode, which leaves the state unchanged.
// Rotation modes run a CORDIC for sine and cosine of the half angle, one
// step per cycle. The axis mode then spends one lane pass scaling the
// axis. Each Hamilton product is done by four lanes in parallel, one per
// output component, a pass being multiply, sum and round, then capture
// into the result register. The transform takes two passes.
// One word is in flight at a time; in_ch.ready is high only when idle
// with the output register empty, so a new word is taken at the earliest
// in the cycle after the previous result leaves.
// The result sits in an output register until out_ch.ready takes it, and a
// stalled receiver simply holds the block. Reset drops any word in flight.
module quaternion_rotation_unit_core #(
	parameter int COMPONENT_WIDTH = 16,
	parameter int ANGLE_WIDTH = 16,
	parameter int CORDIC_STEPS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	qru_in_if.sink in_ch,
	qru_out_if.source out_ch
);
	localparam int Cw = COMPONENT_WIDTH;
	typedef logic signed [Cw-1:0] comp_t;

	qru_pkg::state_t st_q, st_d;
	comp_t q_q [4];
	comp_t op_q [4];
	comp_t rot_q [4];
	comp_t tmp_q [4];
	comp_t res_q [4];
	logic [3:0] mode_q;
	logic signed [ANGLE_WIDTH-1:0] ang_q;
	logic [1:0] pass_q;
	logic ov_q;

	logic cstart, cdone;
	comp_t s_w, c_w;

	qru_cordic #(.COMPONENT_WIDTH(Cw), .ANGLE_WIDTH(ANGLE_WIDTH),
		.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cstart), .angle(ang_q),
		.done(cdone), .sin_out(s_w), .cos_out(c_w));

	function automatic comp_t sneg(input comp_t v);
		comp_t m;
		m = {1'b1, {(Cw-1){1'b0}}};
		return (v == m) ? ~m : -v;
	endfunction

	// Rotation quaternion: cosine in w, sine on the turn's axis. The axis
	// mode parks sine in x until the scaling pass.
	comp_t rot_d [4];
	comp_t first_d [4];
	logic [1:0] rot_idx;

	always_comb begin
		if (mode_q <= 4'(qru_pkg::MODE_MAKE_Z))
			rot_idx = mode_q[1:0];
		else if (mode_q == 4'(qru_pkg::MODE_MAKE_AX))
			rot_idx = 2'd0;
		else if (mode_q <= 4'(qru_pkg::MODE_PRE_Z))
			rot_idx = 2'(mode_q - 4'(qru_pkg::MODE_PRE_X));
		else
			rot_idx = 2'(mode_q - 4'(qru_pkg::MODE_POST_X));
		rot_d = '{comp_t'(0), comp_t'(0), comp_t'(0), c_w};
		rot_d[rot_idx] = s_w;
		// Modes with no arithmetic pass settle on the first cycle.
		for (int i = 0; i < 4; i++) first_d[i] = q_q[i];
		if (mode_q == 4'(qru_pkg::MODE_LOAD))
			first_d = op_q;
		else if (mode_q == 4'(qru_pkg::MODE_CONJ))
			first_d = '{sneg(q_q[0]), sneg(q_q[1]), sneg(q_q[2]), q_q[3]};
	end

	// Lane operands for a Hamilton product l*r, or axis scaling.
	comp_t la [4][4];
	comp_t lb [4][4];
	logic [3:0] ln [4];
	comp_t lsum [4];
	comp_t hl [4], hr [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin hl[i] = q_q[i]; hr[i] = q_q[i]; end
		if (st_q == qru_pkg::ST_HAM2) begin
			for (int i = 0; i < 4; i++) begin hl[i] = q_q[i]; hr[i] = tmp_q[i]; end
		end else begin
			unique case (qru_pkg::mode_t'(mode_q))
				qru_pkg::MODE_PRE_X, qru_pkg::MODE_PRE_Y, qru_pkg::MODE_PRE_Z:
					for (int i = 0; i < 4; i++) begin hl[i] = q_q[i]; hr[i] = rot_q[i]; end
				qru_pkg::MODE_POST_X, qru_pkg::MODE_POST_Y, qru_pkg::MODE_POST_Z:
					for (int i = 0; i < 4; i++) begin hl[i] = rot_q[i]; hr[i] = q_q[i]; end
				qru_pkg::MODE_RMUL:
					for (int i = 0; i < 4; i++) begin hl[i] = q_q[i]; hr[i] = op_q[i]; end
				qru_pkg::MODE_LMUL:
					for (int i = 0; i < 4; i++) begin hl[i] = op_q[i]; hr[i] = q_q[i]; end
				qru_pkg::MODE_XFORM: begin
					for (int i = 0; i < 3; i++) begin hl[i] = op_q[i]; hr[i] = sneg(q_q[i]); end
					hl[3] = op_q[3]; hr[3] = q_q[3];
				end
				default: ;
			endcase
		end
		la[0] = '{hl[0], hl[1], hl[2], hl[3]}; lb[0] = '{hr[3], hr[2], hr[1], hr[0]};
		ln[0] = 4'b0100;
		la[1] = '{hl[0], hl[1], hl[2], hl[3]}; lb[1] = '{hr[2], hr[3], hr[0], hr[1]};
		ln[1] = 4'b0001;
		la[2] = '{hl[0], hl[1], hl[2], hl[3]}; lb[2] = '{hr[1], hr[0], hr[3], hr[2]};
		ln[2] = 4'b0010;
		la[3] = '{hl[0], hl[1], hl[2], hl[3]}; lb[3] = '{hr[0], hr[1], hr[2], hr[3]};
		ln[3] = 4'b0111;
		if (st_q == qru_pkg::ST_AXIS) begin
			for (int i = 0; i < 4; i++) begin
				la[i] = '{rot_q[0], comp_t'(0), comp_t'(0), comp_t'(0)};
				lb[i] = '{op_q[i], comp_t'(0), comp_t'(0), comp_t'(0)};
				ln[i] = 4'b0000;
			end
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_lane
		qru_lane #(.COMPONENT_WIDTH(Cw)) u_lane (
			.clk(clk), .a(la[g]), .b(lb[g]), .neg(ln[g]), .sum(lsum[g]));
	end

	logic is_rot, is_ham;
	assign is_rot = (mode_q <= 4'(qru_pkg::MODE_POST_Z));
	assign is_ham = (mode_q >= 4'(qru_pkg::MODE_PRE_X)) && (mode_q <= 4'(qru_pkg::MODE_LMUL))
		|| (mode_q == 4'(qru_pkg::MODE_XFORM));

	assign in_ch.ready = (st_q == qru_pkg::ST_IDLE) && !ov_q;
	logic acc;
	assign acc = in_ch.valid && in_ch.ready;

	always_comb begin
		st_d = st_q;
		cstart = 1'b0;
		unique case (st_q)
			qru_pkg::ST_IDLE: if (acc) st_d = qru_pkg::ST_CORDIC;
			qru_pkg::ST_CORDIC: begin
				// Decide the route on the first cycle after acceptance.
				if (pass_q == 2'd0) begin
					if (is_rot) cstart = 1'b1;
					else if (is_ham) st_d = qru_pkg::ST_HAM1;
					else st_d = qru_pkg::ST_DONE;
				end else if (cdone) begin
					if (mode_q == 4'(qru_pkg::MODE_MAKE_AX)) st_d = qru_pkg::ST_AXIS;
					else if (is_ham) st_d = qru_pkg::ST_HAM1;
					else st_d = qru_pkg::ST_DONE;
				end
			end
			qru_pkg::ST_AXIS: if (pass_q == 2'd2) st_d = qru_pkg::ST_DONE;
			qru_pkg::ST_HAM1: if (pass_q == 2'd2) begin
				st_d = (mode_q == 4'(qru_pkg::MODE_XFORM)) ? qru_pkg::ST_HAM2 : qru_pkg::ST_DONE;
			end
			qru_pkg::ST_HAM2: if (pass_q == 2'd2) st_d = qru_pkg::ST_DONE;
			qru_pkg::ST_DONE: st_d = qru_pkg::ST_IDLE;
			default: st_d = qru_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= qru_pkg::ST_IDLE;
			pass_q <= '0;
			ov_q <= 1'b0;
			for (int i = 0; i < 3; i++) q_q[i] <= '0;
			q_q[3] <= comp_t'(1) <<< (Cw - 2);
		end else begin
			st_q <= st_d;
			if (st_d != st_q) pass_q <= '0;
			else if (st_q == qru_pkg::ST_CORDIC) pass_q <= 2'd1;
			else if (st_q != qru_pkg::ST_IDLE) pass_q <= pass_q + 2'd1;
			if (st_q == qru_pkg::ST_DONE) begin
				ov_q <= 1'b1;
				if (mode_q != 4'(qru_pkg::MODE_XFORM))
					for (int i = 0; i < 4; i++) q_q[i] <= res_q[i];
			end else if (out_ch.valid && out_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mode_q <= in_ch.mode;
			ang_q <= in_ch.angle;
			op_q <= '{in_ch.operand_x, in_ch.operand_y, in_ch.operand_z, in_ch.operand_w};
		end
		if (st_q == qru_pkg::ST_CORDIC && cdone) rot_q <= rot_d;
		if (st_q == qru_pkg::ST_HAM1 && pass_q == 2'd2) tmp_q <= lsum;
		if (st_q == qru_pkg::ST_CORDIC && pass_q == 2'd0)
			res_q <= first_d;
		else if (st_q == qru_pkg::ST_CORDIC && cdone)
			res_q <= rot_d;
		else if (st_q == qru_pkg::ST_AXIS && pass_q == 2'd2)
			res_q <= '{lsum[0], lsum[1], lsum[2], rot_q[3]};
		else if ((st_q == qru_pkg::ST_HAM1 || st_q == qru_pkg::ST_HAM2) && pass_q == 2'd2)
			res_q <= lsum;
		if (st_q == qru_pkg::ST_DONE) begin
			out_ch.result_x <= res_q[0];
			out_ch.result_y <= res_q[1];
			out_ch.result_z <= res_q[2];
			out_ch.result_w <= res_q[3];
		end
	end

	assign out_ch.valid = ov_q;
endmodule
`default_nettype wire

// ===== bench/tb_quaternion_rotation_unit_core.sv =====
`default_nettype none
module tb_quaternion_rotation_unit_core;

	localparam int CW = 16;
	localparam int AW = 16;
	localparam int FR = CW - 2;
	localparam int STEPS = 16;
	localparam longint CYCLE_LIMIT = 600000;

	typedef logic signed [CW-1:0] comp_t;
	typedef struct {
		comp_t x;
		comp_t y;
		comp_t z;
		comp_t w;
	} quat_word_t;
	typedef longint quat_t [4];

	typedef struct {
		qru_pkg::mode_t mode;
		logic signed [AW-1:0] angle;
		comp_t op [4];
		bit typed;
		comp_t want [4];
	} stim_row_t;

	logic clk;
	logic arst_n;
	qru_in_if #(.COMPONENT_WIDTH(CW), .ANGLE_WIDTH(AW)) in_ch ();
	qru_out_if #(.COMPONENT_WIDTH(CW)) out_ch ();

	quaternion_rotation_unit_core #(
		.COMPONENT_WIDTH(CW),
		.ANGLE_WIDTH(AW),
		.CORDIC_STEPS(STEPS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Shadow of the block's orientation quaternion, order x, y, z, w.
	quat_t orient;
	quat_word_t pending_results [$];
	stim_row_t rows [$];
	int mismatches = 0;
	longint cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Saturate to the component range.
	function automatic longint sat_comp(input longint v);
		longint hi, lo;
		hi = (longint'(1) <<< (CW - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	// Sum of exact products, rounded half up to FR fraction bits.
	function automatic longint round_fx(input longint sum);
		return sat_comp((sum + (longint'(1) <<< (FR - 1))) >>> FR);
	endfunction

	function automatic quat_t hamilton(input quat_t l, input quat_t r);
		quat_t o;
		o[0] = round_fx(l[0]*r[3] + l[1]*r[2] - l[2]*r[1] + l[3]*r[0]);
		o[1] = round_fx(-l[0]*r[2] + l[1]*r[3] + l[2]*r[0] + l[3]*r[1]);
		o[2] = round_fx(l[0]*r[1] - l[1]*r[0] + l[2]*r[3] + l[3]*r[2]);
		o[3] = round_fx(-l[0]*r[0] - l[1]*r[1] - l[2]*r[2] + l[3]*r[3]);
		return o;
	endfunction

	function automatic quat_t conj_sat(input quat_t q);
		quat_t o;
		o[0] = sat_comp(-q[0]);
		o[1] = sat_comp(-q[1]);
		o[2] = sat_comp(-q[2]);
		o[3] = q[3];
		return o;
	endfunction

	// CORDIC to 30 fraction bits on the half angle, then rounded to FR bits.
	function automatic longint cordic_round(input longint v);
		return sat_comp((v + (longint'(1) <<< (qru_pkg::CordicFrac - FR - 1)))
			>>> (qru_pkg::CordicFrac - FR));
	endfunction

	task automatic half_sin_cos(input logic signed [AW-1:0] a, output longint s,
			output longint c);
		longint x, y, z, nx;
		x = qru_pkg::CordicGain;
		y = 0;
		z = longint'(a) * (longint'(1) <<< (31 - AW));
		for (int i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - qru_pkg::atan_lookup(i[4:0]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + qru_pkg::atan_lookup(i[4:0]);
			end
			x = nx;
		end
		c = cordic_round(x);
		s = cordic_round(y);
	endtask

	// Computes the result word for one input word and advances the shadow state.
	task automatic compute_orientation(input logic [3:0] m, input logic signed [AW-1:0] a,
			input comp_t op_in [4], output quat_word_t res_word);
		quat_t op, rot, res;
		longint s, c;
		for (int i = 0; i < 4; i++) begin
			op[i] = op_in[i];
			rot[i] = 0;
			res[i] = orient[i];
		end
		if (m <= qru_pkg::MODE_POST_Z) begin
			half_sin_cos(a, s, c);
			if (m == qru_pkg::MODE_MAKE_AX) begin
				for (int i = 0; i < 3; i++)
					rot[i] = round_fx(s * op[i]);
			end else if (m < qru_pkg::MODE_MAKE_AX) begin
				rot[m - qru_pkg::MODE_MAKE_X] = s;
			end else if (m <= qru_pkg::MODE_PRE_Z) begin
				rot[m - qru_pkg::MODE_PRE_X] = s;
			end else begin
				rot[m - qru_pkg::MODE_POST_X] = s;
			end
			rot[3] = c;
		end
		if (m <= qru_pkg::MODE_MAKE_AX)
			res = rot;
		else if (m <= qru_pkg::MODE_PRE_Z)
			res = hamilton(orient, rot);
		else if (m <= qru_pkg::MODE_POST_Z)
			res = hamilton(rot, orient);
		else if (m == qru_pkg::MODE_RMUL)
			res = hamilton(orient, op);
		else if (m == qru_pkg::MODE_LMUL)
			res = hamilton(op, orient);
		else if (m == qru_pkg::MODE_LOAD)
			res = op;
		else if (m == qru_pkg::MODE_CONJ)
			res = conj_sat(orient);
		else if (m == qru_pkg::MODE_XFORM)
			res = hamilton(orient, hamilton(op, conj_sat(orient)));
		if (m != qru_pkg::MODE_XFORM)
			orient = res;
		res_word.x = comp_t'(res[0]);
		res_word.y = comp_t'(res[1]);
		res_word.z = comp_t'(res[2]);
		res_word.w = comp_t'(res[3]);
	endtask

	task automatic add_row(input qru_pkg::mode_t m, input int a, input int ox, input int oy,
			input int oz, input int ow, input bit typed, input int wx, input int wy,
			input int wz, input int ww);
		stim_row_t r;
		r.mode = m;
		r.angle = AW'(a);
		r.op[0] = comp_t'(ox); r.op[1] = comp_t'(oy);
		r.op[2] = comp_t'(oz); r.op[3] = comp_t'(ow);
		r.typed = typed;
		r.want[0] = comp_t'(wx); r.want[1] = comp_t'(wy);
		r.want[2] = comp_t'(wz); r.want[3] = comp_t'(ww);
		rows.push_back(r);
	endtask

	// Offers one word, waits for the handshake, then records the expected result.
	task automatic offer_word(input logic [3:0] m, input logic signed [AW-1:0] a,
			input comp_t op [4], input bit typed, input comp_t want [4]);
		quat_word_t exp_word;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.mode = m;
		in_ch.angle = a;
		in_ch.operand_x = op[0];
		in_ch.operand_y = op[1];
		in_ch.operand_z = op[2];
		in_ch.operand_w = op[3];
		in_ch.valid = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		compute_orientation(m, a, op, exp_word);
		if (typed) begin
			exp_word.x = want[0];
			exp_word.y = want[1];
			exp_word.z = want[2];
			exp_word.w = want[3];
		end
		pending_results.push_back(exp_word);
	endtask

	// The sender drops valid and pauses until every result has come.
	task automatic drain_results();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic comp_t rand_comp();
		if ($urandom_range(99) < 60)
			return comp_t'($signed($urandom_range(32768)) - 16384);
		return comp_t'($urandom);
	endfunction

	// Receiver: random stalls, plus a counted long hold-off when requested.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Result checker against the oldest expected word.
	always @(posedge clk) begin
		quat_word_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with no expectation waiting");
				mismatches++;
			end else begin
				e = pending_results.pop_front();
				if (out_ch.result_x !== e.x) begin
					$error("result_x expected %0d actual %0d", e.x, out_ch.result_x);
					mismatches++;
				end
				if (out_ch.result_y !== e.y) begin
					$error("result_y expected %0d actual %0d", e.y, out_ch.result_y);
					mismatches++;
				end
				if (out_ch.result_z !== e.z) begin
					$error("result_z expected %0d actual %0d", e.z, out_ch.result_z);
					mismatches++;
				end
				if (out_ch.result_w !== e.w) begin
					$error("result_w expected %0d actual %0d", e.w, out_ch.result_w);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		comp_t op [4];
		comp_t none [4];
		logic [3:0] m;
		logic signed [AW-1:0] a;
		int pick;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.mode = qru_pkg::MODE_NONE;
		in_ch.angle = '0;
		in_ch.operand_x = '0;
		in_ch.operand_y = '0;
		in_ch.operand_z = '0;
		in_ch.operand_w = '0;
		out_ch.ready = 1'b0;
		for (int i = 0; i < 4; i++)
			none[i] = '0;
		orient[0] = 0;
		orient[1] = 0;
		orient[2] = 0;
		orient[3] = longint'(1) <<< FR;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table. The unused mode right after reset must return identity.
		add_row(qru_pkg::MODE_NONE, 1000, 5, 6, 7, 8, 1, 0, 0, 0, 16384);
		add_row(qru_pkg::MODE_MAKE_X, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(qru_pkg::MODE_MAKE_Y, 16384, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(qru_pkg::MODE_MAKE_Z, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(qru_pkg::MODE_MAKE_AX, 32767, 16384, 0, 0, -32768, 0, 0, 0, 0, 0);
		add_row(qru_pkg::MODE_MAKE_AX, -32768, -32768, -32768, 32767, 32767, 0, 0, 0, 0, 0);
		add_row(qru_pkg::MODE_PRE_X, 1234, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(qru_pkg::MODE_PRE_Y, -20000, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(qru_pkg::MODE_PRE_Z, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(qru_pkg::MODE_POST_X, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(qru_pkg::MODE_POST_Y, 8192, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(qru_pkg::MODE_POST_Z, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(qru_pkg::MODE_LOAD, 0, 32767, -32768, 32767, -32768, 1,
			32767, -32768, 32767, -32768);
		add_row(qru_pkg::MODE_RMUL, 0, -32768, 32767, -32768, 32767, 0, 0, 0, 0, 0);
		add_row(qru_pkg::MODE_LMUL, 0, 32767, 32767, -32768, -32768, 0, 0, 0, 0, 0);
		// Conjugating the most negative value saturates to the largest positive one.
		add_row(qru_pkg::MODE_LOAD, 0, -32768, -32768, -32768, 5, 1,
			-32768, -32768, -32768, 5);
		add_row(qru_pkg::MODE_CONJ, 321, 1, 2, 3, 4, 1, 32767, 32767, 32767, 5);
		add_row(qru_pkg::MODE_LOAD, 0, -32768, 0, 0, 16384, 1, -32768, 0, 0, 16384);
		add_row(qru_pkg::MODE_XFORM, 0, 16384, -32768, 32767, 0, 0, 0, 0, 0, 0);
		add_row(qru_pkg::MODE_CONJ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(qru_pkg::MODE_NONE, 777, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(qru_pkg::MODE_LOAD, 0, 4096, 8192, -4096, 12000, 0, 0, 0, 0, 0);
		add_row(qru_pkg::MODE_XFORM, 0, 10000, -5000, 2500, 0, 0, 0, 0, 0, 0);
		foreach (rows[i])
			offer_word(rows[i].mode, rows[i].angle, rows[i].op, rows[i].typed,
				rows[i].want);
		drain_results();

		// Random part in four idling phases. Mostly rotations and products on
		// near-unit values, with loads now and then to keep the state bounded.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 47; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 47; end
				default: begin idle_pct = 26; stall_pct = 26; end
			endcase
			if (phase == 1)
				hold_cycles = 400;
			for (int n = 0; n < 195; n++) begin
				pick = $urandom_range(99);
				if (pick < 8)
					m = qru_pkg::MODE_LOAD;
				else if (pick < 12)
					m = qru_pkg::MODE_NONE;
				else
					m = 4'($urandom_range(14));
				a = AW'($urandom);
				for (int i = 0; i < 4; i++)
					op[i] = rand_comp();
				offer_word(m, a, op, 1'b0, none);
			end
			drain_results();
		end

		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
`default_nettype wire
